/* src/bit_copy_jump_cpu_unit_macros.svh */
// Assertion macros shared by the bit-copy-jump unit RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef BIT_COPY_JUMP_CPU_UNIT_MACROS_SVH
`define BIT_COPY_JUMP_CPU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BCJ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BCJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bcj_pkg.sv */
// Types and constants for the bit-copy-jump unit.
// No dependencies.
`timescale 1ns / 1ps

package bcj_pkg;

    localparam int WORD_W = 32;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_BAD_WR  = 3'd2;
    localparam logic [2:0] ST_BAD_RD  = 3'd3;
    localparam logic [2:0] ST_BAD_JMP = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] word_index;
        logic [31:0] word_data;
        logic [7:0]  input_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        input_used;
        logic [31:0] pc_now;
    } t_result;

endpackage

/* src/bit_copy_jump_cpu_unit.sv */
// Top level of the bit-copy-jump unit: start pc register, output word register.
// Depends on bcj_pkg, bcj_seq and the macros header.
`timescale 1ns / 1ps
`include "bit_copy_jump_cpu_unit_macros.svh"

// After reset the unit zeroes its word memory, one word a cycle, so i_valid is
// not taken until the clear sweep has finished; i_cfg_we is taken throughout.
// A step runs three instruction fetches, then one or two data reads and at most
// one write-back, all through the single memory port; a step that faults, halts
// or only jumps does no data read. A step on a stopped machine returns its stored
// status without fetching. The result sits in an output register, so the next
// word may be accepted while it waits on i_ready.
module bit_copy_jump_cpu_unit #(
    parameter int MEM_WORDS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [15:0] i_word_index,
    input  logic [31:0] i_word_data,
    input  logic [7:0]  i_input_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_input_used,
    output logic [31:0] o_pc_now
);
    import bcj_pkg::*;

    logic [31:0] r_start_pc;
    logic        r_full, n_full;
    t_result     r_out, n_out;

    t_item   item;
    logic    res_valid, res_ready;
    t_result res;

    assign item = '{req_type: i_req_type, word_index: i_word_index,
                    word_data: i_word_data, input_byte: i_input_byte};

    bcj_seq #(
        .MEM_WORDS (MEM_WORDS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (item),
        .i_start_pc  (r_start_pc),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_full || i_ready;

    always_comb begin
        n_full = r_full;
        n_out  = r_out;
        if (res_valid && res_ready) begin
            n_full = 1'b1;
            n_out  = res;
        end else if (i_ready) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= '0;
            r_full     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_pc <= i_cfg_data;
            end
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid      = r_full;
    assign o_status     = r_out.status;
    assign o_out_valid  = r_out.out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_input_used = r_out.input_used;
    assign o_pc_now     = r_out.pc_now;

    `BCJ_ASSERT_NEXT(a_res_lands, res_valid && res_ready, r_full,
        "finished word not captured")
    `BCJ_ASSERT_NOW(a_no_overrun, r_full && !i_ready, !res_ready,
        "output register overwritten while held")
    `BCJ_ASSERT_NOW(a_status_io, r_full && (o_out_valid || o_input_used),
        o_status == ST_OK,
        "character I/O with a non-ok status")

endmodule

/* src/bcj_mem.sv */
// Single-port word memory with registered read.
// Depends on bcj_pkg.
`timescale 1ns / 1ps

module bcj_mem #(
    parameter int MEM_WORDS = 65536,
    parameter int ADDR_W    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [bcj_pkg::WORD_W-1:0] i_wdata,
    output logic [bcj_pkg::WORD_W-1:0] o_rdata
);
    import bcj_pkg::*;

    logic [WORD_W-1:0] r_mem [MEM_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

/* src/bcj_seq.sv */
// Instruction sequencer: clear sweep, loads, fetch, execute and write-back
// over the word memory. Depends on bcj_pkg, bcj_mem and the macros header.
`timescale 1ns / 1ps
`include "bit_copy_jump_cpu_unit_macros.svh"

module bcj_seq #(
    parameter int MEM_WORDS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bcj_pkg::t_item   i_item,
    input  logic [31:0]      i_start_pc,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output bcj_pkg::t_result o_res
);
    import bcj_pkg::*;

    localparam int ADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_LOAD = 11'b000_0000_0100,
        S_F0   = 11'b000_0000_1000,
        S_F1   = 11'b000_0001_0000,
        S_F2   = 11'b000_0010_0000,
        S_EX   = 11'b000_0100_0000,
        S_IO   = 11'b000_1000_0000,
        S_RB   = 11'b001_0000_0000,
        S_RA   = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [31:0]       r_pc, n_pc;
    logic [2:0]        r_stop, n_stop;
    t_item             r_item, n_item;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_b, n_b;
    logic [31:0]       r_c, n_c;
    logic              r_bit, n_bit;
    logic              r_rd_ok, n_rd_ok;
    t_result           r_res, n_res;

    logic              mem_en, mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    logic [1:0]        fetch_k;
    logic [27:0]       fetch_idx;
    logic              fetch_ok;
    logic [WORD_W-1:0] fetched;
    logic [31:0]       c_now;
    logic              a_bad, b_bad, c_bad, a_eq_b;
    logic [4:0]        byte_sh;
    logic [31:0]       byte_word;
    logic [7:0]        sel_byte;
    logic [31:0]       widx32;
    logic              load_ok;

    bcj_mem #(
        .MEM_WORDS (MEM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        fetch_k   = 2'd0;
        if (r_state == S_F1) fetch_k = 2'd1;
        if (r_state == S_F2) fetch_k = 2'd2;
        fetch_idx = {1'b0, r_pc[31:5]} + 28'(fetch_k);
        fetch_ok  = (fetch_idx < 28'(MEM_WORDS));
        fetched   = r_rd_ok ? mem_rdata : '0;
        c_now     = r_pc + fetched;
        a_bad     = ({1'b0, r_a[31:5]} >= 28'(MEM_WORDS));
        b_bad     = ({1'b0, r_b[31:5]} >= 28'(MEM_WORDS));
        c_bad     = ({1'b0, c_now[31:5]} >= 28'(MEM_WORDS));
        a_eq_b    = (r_a == r_b);
        byte_sh   = {r_a[4:3], 3'b000};
        byte_word = fetched >> byte_sh;
        sel_byte  = byte_word[7:0];
        widx32    = 32'(r_item.word_index);
        load_ok   = (widx32 < 32'(MEM_WORDS));
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_pc      = r_pc;
        n_stop    = r_stop;
        n_item    = r_item;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_bit     = r_bit;
        n_rd_ok   = r_rd_ok;
        n_res     = r_res;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = fetch_idx[ADDR_W-1:0];
        mem_wdata = '0;

        unique case (r_state)
            S_CLR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_item = i_item;
                    if (i_item.req_type == REQ_LOAD) begin
                        n_state = S_LOAD;
                    end else if (r_stop != ST_OK) begin
                        n_res   = '{status: r_stop, out_valid: 1'b0, out_byte: 8'd0,
                                    input_used: 1'b0, pc_now: r_pc};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_F0;
                    end
                end
            end
            S_LOAD: begin
                mem_en    = load_ok;
                mem_we    = load_ok;
                mem_addr  = widx32[ADDR_W-1:0];
                mem_wdata = r_item.word_data;
                n_pc      = i_start_pc;
                n_stop    = ST_OK;
                n_res     = '{status: ST_OK, out_valid: 1'b0, out_byte: 8'd0,
                              input_used: 1'b0, pc_now: i_start_pc};
                n_state   = S_DONE;
            end
            S_F0: begin
                mem_en  = fetch_ok;
                n_rd_ok = fetch_ok;
                n_state = S_F1;
            end
            S_F1: begin
                n_a     = c_now;
                mem_en  = fetch_ok;
                n_rd_ok = fetch_ok;
                n_state = S_F2;
            end
            S_F2: begin
                n_b     = c_now;
                mem_en  = fetch_ok;
                n_rd_ok = fetch_ok;
                n_state = S_EX;
            end
            S_EX: begin
                n_c     = c_now;
                n_rd_ok = 1'b1;
                n_res   = '{status: ST_OK, out_valid: 1'b0, out_byte: 8'd0,
                            input_used: 1'b0, pc_now: r_pc};
                if (a_bad) begin
                    n_stop       = ST_BAD_WR;
                    n_res.status = ST_BAD_WR;
                    n_state      = S_DONE;
                end else if (b_bad) begin
                    n_stop       = ST_BAD_RD;
                    n_res.status = ST_BAD_RD;
                    n_state      = S_DONE;
                end else if (c_bad) begin
                    n_stop       = ST_BAD_JMP;
                    n_res.status = ST_BAD_JMP;
                    n_state      = S_DONE;
                end else if (a_eq_b && (c_now == r_pc)) begin
                    n_stop       = ST_HALT;
                    n_res.status = ST_HALT;
                    n_state      = S_DONE;
                end else if (a_eq_b && (r_a == r_pc)) begin
                    n_pc         = c_now;
                    n_res.pc_now = c_now;
                    n_state      = S_DONE;
                end else if (a_eq_b) begin
                    mem_en   = 1'b1;
                    mem_addr = r_a[5+ADDR_W-1:5];
                    n_state  = S_IO;
                end else begin
                    mem_en   = 1'b1;
                    mem_addr = r_b[5+ADDR_W-1:5];
                    n_state  = S_RB;
                end
            end
            S_IO: begin
                n_pc         = r_c;
                n_res.pc_now = r_c;
                if (sel_byte != 8'd0) begin
                    n_res.out_valid = 1'b1;
                    n_res.out_byte  = sel_byte;
                end else begin
                    mem_en           = 1'b1;
                    mem_we           = 1'b1;
                    mem_addr         = r_a[5+ADDR_W-1:5];
                    mem_wdata        = (fetched & ~(32'hFF << byte_sh))
                                     | (32'(r_item.input_byte) << byte_sh);
                    n_res.input_used = 1'b1;
                end
                n_state = S_DONE;
            end
            S_RB: begin
                n_bit    = fetched[r_b[4:0]];
                mem_en   = 1'b1;
                mem_addr = r_a[5+ADDR_W-1:5];
                n_state  = S_RA;
            end
            S_RA: begin
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                mem_addr     = r_a[5+ADDR_W-1:5];
                mem_wdata    = (fetched & ~(32'h1 << r_a[4:0]))
                             | (32'(r_bit) << r_a[4:0]);
                n_pc         = r_c;
                n_res.pc_now = r_c;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_pc      <= '0;
            r_stop    <= ST_OK;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_pc      <= n_pc;
            r_stop    <= n_stop;
            r_rd_ok   <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_bit  <= n_bit;
        r_res  <= n_res;
    end

    `BCJ_ASSERT_NOW(a_we_states, mem_we,
        (r_state == S_CLR) || (r_state == S_LOAD) || (r_state == S_IO) || (r_state == S_RA),
        "memory write outside a write state")
    `BCJ_ASSERT_NOW(a_io_excl, r_state == S_DONE,
        !(r_res.out_valid && r_res.input_used),
        "word both outputs and consumes a byte")
    `BCJ_ASSERT_NEXT(a_clr_hold, (r_state == S_CLR) && (r_clr_cnt != LAST_ADDR),
        r_state == S_CLR,
        "clear sweep left early")

endmodule
